>>> hdl/pcl_pkg.sv
// Shared types and codes for the positional list unit.
// Used by pcl_cell and positional_circular_list_unit; no dependencies.
`default_nettype none

package pcl_pkg;

    // Index width that covers positions and counts of lists up to 127 deep
    localparam int IDX_W = 7;

    // Request codes
    localparam logic [2:0] REQ_APPEND  = 3'd0;
    localparam logic [2:0] REQ_PREPEND = 3'd1;
    localparam logic [2:0] REQ_INSERT  = 3'd2;
    localparam logic [2:0] REQ_DELETE  = 3'd3;
    localparam logic [2:0] REQ_READ    = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [IDX_W-1:0]   pos;
        logic [IDX_W-1:0]   cnt;
    } cell_cmd_t;

endpackage

`default_nettype wire

>>> hdl/positional_circular_list_unit.sv
// Top level of the positional list unit: request decode, count, read-out sequencer.
// Depends on pcl_pkg and pcl_cell.
//
//  channel | signals                          | dir | payload
//  --------+----------------------------------+-----+----------------------------
//  request | req_valid, req_stall             | in  | req_type, value, position
//  result  | rsp_valid, rsp_stall             | out | item, last, status
//
// Append, prepend, insert, delete and unused codes give one result each. A read
// out of N stored values gives N results, the first after the sequencer has
// entered S_READ, then one per cycle while the result side does not stall;
// the chain rotates left once per result, so the list is back in order after the
// last one. A new request is taken only when the read out is done and the result
// register is free or being drained.
// Reset clears the count and the sequencer; cell contents are left as they are.
`default_nettype none

module positional_circular_list_unit #(
    parameter int DEPTH = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  wire  [2:0]          req_type,
    input  wire  signed [31:0]  value,
    input  wire  [4:0]          position,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output logic signed [31:0]  item,
    output logic                last,
    output logic [1:0]          status
);
    import pcl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   rd_left_reg, rd_left_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic [31:0]     item_reg, item_next;
    logic            last_reg, last_next;
    logic [1:0]      status_reg, status_next;

    cell_cmd_t       cmd;
    logic [31:0]     cell_value [DEPTH];
    logic            out_free;
    logic            req_xfer;
    logic            is_full;
    logic            is_empty;
    logic [IDX_W-1:0] pos_ext;
    logic [IDX_W-1:0] cnt_ext;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == S_IDLE) && out_free);
    assign req_xfer  = req_valid && !req_stall;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign pos_ext   = IDX_W'(position);
    assign cnt_ext   = IDX_W'(count_reg);

    // Chain of cells
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [31:0] prev_v;
        logic [31:0] next_v;
        if (g == 0)
        begin : g_first
            assign prev_v = '0;
        end
        else
        begin : g_mid_prev
            assign prev_v = cell_value[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_end
            assign next_v = '0;
        end
        else
        begin : g_mid_next
            assign next_v = cell_value[g+1];
        end
        pcl_cell #(
            .IDX (g)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .new_value  (value),
            .head_value (cell_value[0]),
            .prev_value (prev_v),
            .next_value (next_v),
            .value      (cell_value[g])
        );
    end

    // Request decode and read-out sequencing
    always_comb
    begin
        cmd.op         = CELL_HOLD;
        cmd.pos        = pos_ext;
        cmd.cnt        = cnt_ext;
        count_next     = count_reg;
        state_next     = state_reg;
        rd_left_next   = rd_left_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        item_next      = item_reg;
        last_next      = last_reg;
        status_next    = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    rsp_valid_next = 1'b1;
                    item_next      = '0;
                    last_next      = 1'b1;
                    status_next    = ST_OK;
                    unique case (req_type) inside
                        REQ_APPEND, REQ_PREPEND, REQ_INSERT:
                        begin
                            if (req_type == REQ_APPEND)
                                cmd.pos = cnt_ext;
                            else if (req_type == REQ_PREPEND)
                                cmd.pos = '0;
                            if (is_full)
                                status_next = ST_FULL;
                            else if (req_type == REQ_INSERT && pos_ext > cnt_ext)
                                status_next = ST_RANGE;
                            else
                            begin
                                cmd.op     = CELL_INS;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (is_empty)
                                status_next = ST_EMPTY;
                            else if (pos_ext >= cnt_ext)
                                status_next = ST_RANGE;
                            else
                            begin
                                cmd.op     = CELL_DEL;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        REQ_READ:
                        begin
                            if (is_empty)
                                status_next = ST_EMPTY;
                            else
                            begin
                                rsp_valid_next = 1'b0;
                                rd_left_next   = count_reg;
                                state_next     = S_READ;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    item_next      = cell_value[0];
                    last_next      = (rd_left_reg == CW'(1));
                    status_next    = ST_OK;
                    cmd.op         = CELL_ROT;
                    rd_left_next   = rd_left_reg - CW'(1);
                    if (rd_left_reg == CW'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_left_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_left_reg   <= rd_left_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign item      = item_reg;
    assign last      = last_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    // count never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("list count above capacity");

    // no request is taken during read out
    a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> req_stall)
        else $error("request taken during read out");

    // a result without the last marker only comes from a read out in progress
    a_nonlast_read: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !last) |-> (state_reg == S_READ))
        else $error("non-final result outside read out");

    // count only moves on a request transfer
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(req_valid && !req_stall))
        else $error("count changed without a request");
`endif

endmodule

`default_nettype wire

>>> hdl/pcl_cell.sv
// One storage cell of the list chain: holds one value, shifts with its neighbors.
// Depends on pcl_pkg for the command struct and index width.
`default_nettype none

module pcl_cell #(
    parameter int IDX = 0
) (
    input  wire                      clk,
    input  pcl_pkg::cell_cmd_t       cmd,
    input  wire  [31:0]              new_value,
    input  wire  [31:0]              head_value,
    input  wire  [31:0]              prev_value,
    input  wire  [31:0]              next_value,
    output logic [31:0]              value
);
    import pcl_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);
    localparam logic [IDX_W-1:0] MY_IDX1 = IDX_W'(IDX + 1);

    logic [31:0] value_reg;
    logic [31:0] value_next;

    // Next value from the broadcast operation and this cell's place
    always_comb
    begin
        value_next = value_reg;
        case (cmd.op)
            CELL_INS:
            begin
                if (MY_IDX == cmd.pos)
                    value_next = new_value;
                else if (MY_IDX > cmd.pos && MY_IDX <= cmd.cnt)
                    value_next = prev_value;
            end
            CELL_DEL:
            begin
                if (MY_IDX >= cmd.pos && MY_IDX1 < cmd.cnt)
                    value_next = next_value;
            end
            CELL_ROT:
            begin
                if (MY_IDX1 < cmd.cnt)
                    value_next = next_value;
                else if (MY_IDX1 == cmd.cnt)
                    value_next = head_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

>>> verif/positional_circular_list_unit_test.sv
// Self-checking testbench for positional_circular_list_unit: directed and random list requests,
// results compared against a shadow list kept in the testbench.
// Depends on pcl_pkg and the positional_circular_list_unit RTL.
module positional_circular_list_unit_test;
    import pcl_pkg::*;

    localparam int LIST_DEPTH      = 16;
    localparam int RANDOM_ITEMS    = 440;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int LONG_HOLD       = 80;
    localparam int LONG_HOLD_AFTER = 120;

    typedef struct {
        logic [2:0]         kind;
        logic signed [31:0] data;
        logic [4:0]         slot;
        int                 gap;
        bit                 drain;
    } list_request_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic               tail;
        logic [1:0]         code;
    } list_result_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [2:0]         req_type  = REQ_APPEND;
    logic signed [31:0] value     = '0;
    logic [4:0]         position  = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic signed [31:0] item;
    logic               last;
    logic [1:0]         status;

    positional_circular_list_unit #(
        .DEPTH(LIST_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .value     (value),
        .position  (position),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .item      (item),
        .last      (last),
        .status    (status)
    );

    // Stimulus and scoreboard state
    list_request_t      request_backlog[$];
    list_result_t       expected_results[$];
    logic signed [31:0] shadow_cells[LIST_DEPTH];
    int                 shadow_count      = 0;
    int                 planned_count     = 0;
    int                 request_total     = 0;
    int                 requests_accepted = 0;
    int                 results_seen      = 0;
    int                 fail_count        = 0;
    int                 idle_cycles       = 0;
    bit                 req_transfer      = 1'b0;
    bit                 rsp_transfer      = 1'b0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Shadow list: insert before index 'at', returns the status code
    function automatic logic [1:0] shadow_insert(int at, logic signed [31:0] v);
        int i;
        if (shadow_count >= LIST_DEPTH)
            return ST_FULL;
        if (at > shadow_count)
            return ST_RANGE;
        for (i = shadow_count; i > at; i--)
            shadow_cells[i] = shadow_cells[i - 1];
        shadow_cells[at] = v;
        shadow_count++;
        return ST_OK;
    endfunction

    // Shadow list: remove index 'at', returns the status code
    function automatic logic [1:0] shadow_remove(int at);
        int i;
        if (shadow_count == 0)
            return ST_EMPTY;
        if (at >= shadow_count)
            return ST_RANGE;
        for (i = at; i + 1 < shadow_count; i++)
            shadow_cells[i] = shadow_cells[i + 1];
        shadow_count--;
        return ST_OK;
    endfunction

    // Apply one accepted request to the shadow list and queue the results it causes
    task automatic predict_list_op(input logic [2:0] kind, input logic signed [31:0] data,
                                   input logic [4:0] slot);
        logic [1:0] code;
        int         i;
        code = ST_OK;
        case (kind)
            REQ_APPEND:  code = shadow_insert(shadow_count, data);
            REQ_PREPEND: code = shadow_insert(0, data);
            REQ_INSERT:  code = shadow_insert(int'(slot), data);
            REQ_DELETE:  code = shadow_remove(int'(slot));
            REQ_READ:    if (shadow_count == 0) code = ST_EMPTY;
            default:     code = ST_OK;
        endcase
        if (kind == REQ_READ && shadow_count != 0) begin
            for (i = 0; i < shadow_count; i++)
                expected_results.push_back('{data: shadow_cells[i],
                                             tail: (i + 1 == shadow_count),
                                             code: ST_OK});
        end
        else begin
            expected_results.push_back('{data: 32'sd0, tail: 1'b1, code: code});
        end
    endtask

    // Queue a request; the planned count only steers the random mix
    task automatic add_request(input logic [2:0] kind, input logic signed [31:0] data,
                               input logic [4:0] slot, input int gap, input bit drain);
        request_backlog.push_back('{kind: kind, data: data, slot: slot, gap: gap, drain: drain});
        case (kind)
            REQ_APPEND, REQ_PREPEND:
                if (planned_count < LIST_DEPTH) planned_count++;
            REQ_INSERT:
                if (planned_count < LIST_DEPTH && int'(slot) <= planned_count) planned_count++;
            REQ_DELETE:
                if (planned_count > 0 && int'(slot) < planned_count) planned_count--;
            default: ;
        endcase
    endtask

    // Request driver: one item at a time, drawn gap before each, fields held while stalled
    list_request_t current_req;
    bit            have_req = 1'b0;
    int            gap_left = 0;

    always @(negedge clk) begin
        logic next_valid;
        next_valid = req_valid;
        if (req_valid && req_transfer)
            next_valid = 1'b0;
        req_transfer = 1'b0;
        if (rst_n && !next_valid) begin
            if (!have_req && request_backlog.size() > 0) begin
                current_req = request_backlog.pop_front();
                have_req    = 1'b1;
                gap_left    = current_req.gap;
            end
            if (have_req) begin
                if (current_req.drain && expected_results.size() != 0) begin
                    // hold until every outstanding result has come back
                end
                else if (gap_left > 0) begin
                    gap_left--;
                end
                else begin
                    req_type   <= current_req.kind;
                    value      <= current_req.data;
                    position   <= current_req.slot;
                    next_valid = 1'b1;
                    have_req   = 1'b0;
                end
            end
        end
        req_valid <= next_valid;
    end

    // Result receiver: random stall after each transfer, one long hold-off part way through
    int hold_left      = 0;
    int long_hold_left = 0;
    bit long_hold_done = 1'b0;

    always @(negedge clk) begin
        logic next_stall;
        next_stall = 1'b0;
        if (rsp_transfer) begin
            rsp_transfer = 1'b0;
            // every fourth block of forty results streams with no stall
            hold_left = ((results_seen / 40) % 4 == 3) ? 0 : $urandom_range(0, 6);
        end
        if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD;
        end
        if (long_hold_left > 0) begin
            long_hold_left--;
            next_stall = 1'b1;
        end
        else if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
        end
        rsp_stall <= next_stall;
    end

    // Monitor: check results first, then predict for the request taken at this edge
    always @(posedge clk) begin
        list_result_t want;
        if (rst_n) begin
            if (rsp_valid && !rsp_stall) begin
                rsp_transfer = 1'b1;
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result transfer with none expected: item %0d last %0d status %0d",
                           item, last, status);
                    fail_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (item !== want.data) begin
                        $error("item mismatch: expected %0d, actual %0d", want.data, item);
                        fail_count++;
                    end
                    if (last !== want.tail) begin
                        $error("last mismatch: expected %0d, actual %0d", want.tail, last);
                        fail_count++;
                    end
                    if (status !== want.code) begin
                        $error("status mismatch: expected %0d, actual %0d", want.code, status);
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall) begin
                req_transfer = 1'b1;
                requests_accepted++;
                predict_list_op(req_type, value, position);
            end
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Watchdog on cycles with no transfer on either channel
    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // Stimulus build, reset, and end of run
    initial begin
        int                 n;
        int                 roll;
        bit                 grow;
        bit                 stream;
        logic [2:0]         kind;
        logic signed [31:0] data;
        logic [4:0]         slot;

        // Directed: empty cases, all insert forms, fill to full, full and range errors
        add_request(REQ_READ,    32'sd0,           5'd0,  0, 1'b0);
        add_request(REQ_DELETE,  32'sd0,           5'd0,  1, 1'b0);
        add_request(REQ_APPEND,  32'sh7FFF_FFFF,   5'd0,  0, 1'b0);
        add_request(REQ_PREPEND, 32'sh8000_0000,   5'd0,  2, 1'b0);
        add_request(REQ_INSERT,  -32'sd1,          5'd1,  0, 1'b0);
        add_request(REQ_INSERT,  32'sd5,           5'd4,  0, 1'b0);
        add_request(REQ_INSERT,  32'sd0,           5'd3,  3, 1'b0);
        add_request(REQ_INSERT,  32'sd1,           5'd0,  0, 1'b0);
        for (n = 0; n < 11; n++)
            add_request(n[0] ? REQ_PREPEND : REQ_APPEND,
                        n[0] ? 32'shAAAA_AAAA + n : 32'sh5555_5555 + n,
                        5'(n), $urandom_range(0, 6), 1'b0);
        add_request(REQ_APPEND,  32'sd7,           5'd0,  0, 1'b0);
        add_request(REQ_INSERT,  32'sd9,           5'd31, 0, 1'b0);
        add_request(REQ_READ,    32'sd0,           5'd0,  0, 1'b0);
        add_request(REQ_DELETE,  32'sd0,           5'd16, 0, 1'b0);
        add_request(REQ_DELETE,  32'sd0,           5'd15, 1, 1'b0);
        add_request(REQ_DELETE,  32'sd0,           5'd0,  0, 1'b0);
        add_request(3'd7,        -32'sd1,          5'd31, 0, 1'b0);
        add_request(REQ_READ,    32'sd0,           5'd0,  0, 1'b0);

        // Random: grow toward full, then shrink toward empty, repeatedly
        grow = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (planned_count == LIST_DEPTH)
                grow = 1'b0;
            else if (planned_count == 0)
                grow = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 10)
                kind = REQ_READ;
            else if (roll < 13)
                kind = 3'($urandom_range(5, 7));
            else if (roll < (grow ? 75 : 38))
                kind = 3'($urandom_range(0, 2));
            else
                kind = REQ_DELETE;

            if ($urandom_range(0, 99) < 15)
                slot = 5'($urandom_range(0, 31));
            else if (kind == REQ_DELETE)
                slot = (planned_count > 0) ? 5'($urandom_range(0, planned_count - 1)) : 5'd0;
            else
                slot = 5'($urandom_range(0, planned_count));

            case ($urandom_range(0, 9))
                0:       data = 32'sh8000_0000;
                1:       data = 32'sh7FFF_FFFF;
                2:       data = -32'sd1;
                default: data = $urandom;
            endcase

            // every fourth block of thirty items is sent back to back
            stream = ((n / 30) % 4 == 3);
            add_request(kind, data, slot, stream ? 0 : $urandom_range(0, 6),
                        (n == 0) || (n % 150 == 75));
        end
        request_total = request_backlog.size();

        // Reset, released on a falling edge away from the rising edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (requests_accepted < request_total)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> positional_circular_list_unit.f
hdl/pcl_pkg.sv
hdl/pcl_cell.sv
hdl/positional_circular_list_unit.sv
verif/positional_circular_list_unit_test.sv
